>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// When ante holds, cons holds in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Types, constants and the reciprocal table of the RGB to HSV/HSL converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [14:0] hue;
		logic [15:0] saturation;
		logic [15:0] brightness;
	} result_t;

	typedef enum logic {
		MODE_HSV = 1'b0,
		MODE_HSL = 1'b1
	} mode_t;

	// Divider lanes
	localparam int unsigned NUM_LANES = 3;
	localparam int unsigned LANE_HUE  = 0;
	localparam int unsigned LANE_SAT  = 1;
	localparam int unsigned LANE_BRT  = 2;

	localparam logic [14:0] HUE_FULL_Q6 = 15'd23040;  // 360 deg * 64
	localparam logic [15:0] ONE_Q15     = 16'd32768;
	localparam logic [7:0]  LEVEL_MAX   = 8'd255;

	// Reciprocal floor(2^RECIP_BITS / d); quotient error stays below one
	// for dividends under 2^RECIP_BITS.
	localparam int RECIP_BITS = 24;

	typedef logic [0:255][RECIP_BITS:0] recip_tbl_t;

	function automatic recip_tbl_t build_recip_tbl();
		recip_tbl_t      tbl;
		logic [8:0]      rem;
		logic [RECIP_BITS:0] quo;
		for (int d = 0; d < 256; d++) begin
			rem = '0;
			quo = '0;
			if (d != 0) begin
				// restoring long division of 2^RECIP_BITS by d
				for (int i = RECIP_BITS; i >= 0; i--) begin
					rem = {rem[7:0], (i == RECIP_BITS)};
					if (rem >= 9'(d)) begin
						rem    = rem - 9'(d);
						quo[i] = 1'b1;
					end
				end
			end
			tbl[d] = quo;
		end
		return tbl;
	endfunction

	localparam recip_tbl_t RECIP_TBL = build_recip_tbl();

endpackage

`default_nettype wire

>>> src/rgb_to_hsv_hsl_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_hsl_converter: RGB pixel to hue, saturation, value or lightness.
// Six-stage pipeline; a result passes stages s1 to s6 after its pixel is taken.
// Throughput one pixel per clock while result_stall is low; three reciprocal-multiply dividers set depth.
// arst_n clears stage valid bits and sets the mode to HSV.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rgb_to_hsv_hsl_converter (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_wdata,
	input  wire logic             pixel_valid,
	output logic                  pixel_stall,
	input  wire rhc_pkg::pixel_t  pixel,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output rhc_pkg::result_t      result
);
	import rhc_pkg::*;

	localparam int QW = 16;                // quotient width
	localparam int NW = RECIP_BITS;        // dividend width
	localparam int PW = NW + RECIP_BITS + 1;

	mode_t mode_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6;

	// stage 1
	pixel_t pix_s1;
	mode_t  mode_s1;
	// stage 2
	logic [7:0]  mx_s2, mn_s2, c_s2;
	logic [10:0] n_s2;
	mode_t       mode_s2;
	// stages 3..5
	logic [NUM_LANES-1:0][NW-1:0]       num_s3, num_s4, num_s5;
	logic [NUM_LANES-1:0][7:0]          dvs_s3, dvs_s4, dvs_s5;
	logic [NUM_LANES-1:0][RECIP_BITS:0] rcp_s3;
	logic [NUM_LANES-1:0][QW-1:0]       quo_s4, quo_s5;
	logic [NUM_LANES-1:0][NW-1:0]       back_s5;
	logic grey_s3, grey_s4, grey_s5;
	logic szero_s3, szero_s4, szero_s5;
	// stage 6
	result_t res_s6;

	// stall propagates back only through occupied stages
	assign ld_s6 = !v_s6 || !result_stall;
	assign ld_s5 = !v_s5 || ld_s6;
	assign ld_s4 = !v_s4 || ld_s5;
	assign ld_s3 = !v_s3 || ld_s4;
	assign ld_s2 = !v_s2 || ld_s3;
	assign ld_s1 = !v_s1 || ld_s2;

	assign pixel_stall  = !ld_s1;
	assign result_valid = v_s6;
	assign result       = res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HSV;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= mode_t'(cfg_wdata);
			if (ld_s1) v_s1 <= pixel_valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
			if (ld_s5) v_s5 <= v_s4;
			if (ld_s6) v_s6 <= v_s5;
		end
	end

	// ---- stage 1 -> 2: max, min, chroma, hue sector numerator ----
	logic [7:0]  mx_c, mn_c, c_c;
	logic [10:0] n_c, r11, g11, b11, c11, c6;

	always_comb begin
		mx_c = pix_s1.red;
		mn_c = pix_s1.red;
		if (pix_s1.green > mx_c) mx_c = pix_s1.green;
		if (pix_s1.blue > mx_c)  mx_c = pix_s1.blue;
		if (pix_s1.green < mn_c) mn_c = pix_s1.green;
		if (pix_s1.blue < mn_c)  mn_c = pix_s1.blue;
		c_c = mx_c - mn_c;
		r11 = 11'(pix_s1.red);
		g11 = 11'(pix_s1.green);
		b11 = 11'(pix_s1.blue);
		c11 = 11'(c_c);
		c6  = (c11 << 2) + (c11 << 1);
		// n = hue * chroma / 60 deg, kept non-negative (red wrap adds 6 * chroma)
		if (pix_s1.red == mx_c) begin
			if (pix_s1.green < pix_s1.blue) n_c = g11 + c6 - b11;
			else                            n_c = g11 - b11;
		end else if (pix_s1.green == mx_c) begin
			n_c = b11 + (c11 << 1) - r11;
		end else begin
			n_c = r11 + (c11 << 2) - g11;
		end
	end

	// ---- stage 2 -> 3: dividends, divisors, reciprocals ----
	logic [8:0] sum_c;
	logic [7:0] den_c, ds_c, ds_safe, dh_safe;
	logic       grey_c, szero_c;
	logic [NUM_LANES-1:0][NW-1:0]       num_c;
	logic [NUM_LANES-1:0][7:0]          dvs_c;
	logic [NUM_LANES-1:0][RECIP_BITS:0] rcp_c;

	always_comb begin
		sum_c   = 9'(mx_s2) + 9'(mn_s2);
		den_c   = (sum_c > 9'(LEVEL_MAX)) ? 8'(9'd510 - sum_c) : 8'(sum_c);
		ds_c    = (mode_s2 == MODE_HSV) ? mx_s2 : den_c;
		szero_c = (ds_c == 8'd0);
		ds_safe = szero_c ? 8'd1 : ds_c;
		grey_c  = (c_s2 == 8'd0);
		dh_safe = grey_c ? 8'd1 : c_s2;

		dvs_c[LANE_HUE] = dh_safe;
		dvs_c[LANE_SAT] = ds_safe;
		dvs_c[LANE_BRT] = LEVEL_MAX;

		// round(a/d) = floor((2a + d) / 2d); 7680 = 2 * 60 deg * 64
		num_c[LANE_HUE] = (NW'(n_s2) << 13) - (NW'(n_s2) << 9) + NW'(dh_safe);
		num_c[LANE_SAT] = {c_s2, 16'h0000} + NW'(ds_safe);
		if (mode_s2 == MODE_HSV) num_c[LANE_BRT] = {mx_s2, 16'h0000} + NW'(LEVEL_MAX);
		else                     num_c[LANE_BRT] = {sum_c, 15'h0000} + NW'(LEVEL_MAX);

		for (int i = 0; i < NUM_LANES; i++) rcp_c[i] = RECIP_TBL[dvs_c[i]];
	end

	// ---- stage 3 -> 4: estimate quotient, low by at most one ----
	logic [NUM_LANES-1:0][PW-1:0] prod_c;
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++)
			prod_c[i] = PW'(num_s3[i]) * PW'(rcp_s3[i]);
	end

	// ---- stage 4 -> 5: quotient times 2d ----
	logic [NUM_LANES-1:0][QW+8:0] back_c;
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++)
			back_c[i] = (QW+9)'(quo_s4[i]) * (QW+9)'({dvs_s4[i], 1'b0});
	end

	// ---- stage 5 -> 6: one-step correction and special cases ----
	logic [NUM_LANES-1:0][NW-1:0] rem_c;
	logic [NUM_LANES-1:0][QW-1:0] q_c;
	logic [QW-1:0]                hq_c;
	result_t                      res_c;

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			rem_c[i] = num_s5[i] - back_s5[i];
			q_c[i]   = quo_s5[i] + QW'(rem_c[i] >= NW'({dvs_s5[i], 1'b0}));
		end
		hq_c = q_c[LANE_HUE];
		if (hq_c >= QW'(HUE_FULL_Q6)) hq_c = hq_c - QW'(HUE_FULL_Q6);
		res_c.hue        = grey_s5 ? '0 : hq_c[14:0];
		res_c.saturation = szero_s5 ? '0 : q_c[LANE_SAT];
		res_c.brightness = q_c[LANE_BRT];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			pix_s1  <= pixel;
			mode_s1 <= mode_q;
		end
		if (ld_s2) begin
			mx_s2   <= mx_c;
			mn_s2   <= mn_c;
			c_s2    <= c_c;
			n_s2    <= n_c;
			mode_s2 <= mode_s1;
		end
		if (ld_s3) begin
			num_s3   <= num_c;
			dvs_s3   <= dvs_c;
			rcp_s3   <= rcp_c;
			grey_s3  <= grey_c;
			szero_s3 <= szero_c;
		end
		if (ld_s4) begin
			for (int i = 0; i < NUM_LANES; i++)
				quo_s4[i] <= prod_c[i][RECIP_BITS+QW:RECIP_BITS+1];
			num_s4   <= num_s3;
			dvs_s4   <= dvs_s3;
			grey_s4  <= grey_s3;
			szero_s4 <= szero_s3;
		end
		if (ld_s5) begin
			for (int i = 0; i < NUM_LANES; i++)
				back_s5[i] <= back_c[i][NW-1:0];
			quo_s5   <= quo_s4;
			num_s5   <= num_s4;
			dvs_s5   <= dvs_s4;
			grey_s5  <= grey_s4;
			szero_s5 <= szero_s4;
		end
		if (ld_s6) res_s6 <= res_c;
	end

	`ASSERT_CLK(a_hue_range, (result_valid |-> (result.hue < HUE_FULL_Q6)), "hue out of range")
	`ASSERT_CLK(a_frac_range, (result_valid |-> (result.saturation <= ONE_Q15 && result.brightness <= ONE_Q15)), "fraction above one")
	`ASSERT_CLK(a_one_fix, (v_s5 |-> (rem_c[0] < NW'({dvs_s5[0], 2'b00}) && rem_c[1] < NW'({dvs_s5[1], 2'b00}) && rem_c[2] < NW'({dvs_s5[2], 2'b00}))), "quotient estimate off by more than one")
	`ASSERT_NEXT(a_hold_s3, v_s3 && !ld_s3, v_s3 && $stable(num_s3), "stalled item lost in stage 3")
	`ASSERT_NEXT(a_grey_hue, v_s5 && grey_s5 && ld_s6, res_s6.hue == '0, "grey pixel gave nonzero hue")

endmodule

`default_nettype wire

>>> sim/rgb_to_hsv_hsl_converter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_hsl_converter_test
// Streams RGB pixels through the converter in both output modes and checks
// every hue, saturation and brightness field against an in-bench predictor.
// Both handshakes idle and stall at random; one long result hold-off backs
// the pipeline up into its input.
// ----------------------------------------------------------------------------

module rgb_to_hsv_hsl_converter_test;
	import rhc_pkg::*;

	localparam longint HUE_SECTOR_Q6 = 3840;     // 60 deg * 64
	localparam longint HUE_WRAP_Q6   = 23040;    // 360 deg * 64
	localparam longint Q15_ONE       = 32768;
	localparam longint LEVEL_TOP     = 255;
	localparam int     HOLDOFF_AT    = 500;      // items accepted before the long hold-off
	localparam int     HOLDOFF_LEN   = 200;

	// Corners of the color cube, channel ties, grey, hue wrap, tiny HSL divisor
	localparam logic [23:0] CORNER_PIXELS [14] = '{
		24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
		24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080, 24'hFF0001,
		24'hFFFEFE, 24'h7F8080, 24'hAA55AA, 24'h55AA55
	};

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	logic     cfg_wdata;
	logic     pixel_valid;
	logic     pixel_stall;
	pixel_t   pixel;
	logic     result_valid;
	logic     result_stall;
	result_t  result;

	pixel_t   pixel_queue [$];
	result_t  expected_hsx [$];
	mode_t    mode_now;
	bit       offer_open;
	int       burst_left;
	int       gap_left;
	int       idle_pct;
	int       stall_pct;
	int       hold_left;
	bit       hold_done;
	int       accepted_count;
	int       error_count;

	rgb_to_hsv_hsl_converter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	function automatic result_t predict_hsx(pixel_t px, mode_t mode);
		longint  r, g, b, mx, mn, chroma, t, h, sat, bright, sum, dev, den;
		result_t res;
		r = px.red;
		g = px.green;
		b = px.blue;
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		chroma = mx - mn;
		h = 0;
		if (chroma != 0) begin
			// sector priority on ties: red, then green, then blue
			if (mx == r)
				t = HUE_SECTOR_Q6 * (g - b);
			else if (mx == g)
				t = HUE_SECTOR_Q6 * (b - r) + 2 * HUE_SECTOR_Q6 * chroma;
			else
				t = HUE_SECTOR_Q6 * (r - g) + 4 * HUE_SECTOR_Q6 * chroma;
			if (t < 0)
				t += HUE_WRAP_Q6 * chroma;
			h = (2 * t + chroma) / (2 * chroma);
			if (h >= HUE_WRAP_Q6)
				h -= HUE_WRAP_Q6;
		end
		sat = 0;
		if (mode == MODE_HSV) begin
			if (mx != 0)
				sat = (2 * chroma * Q15_ONE + mx) / (2 * mx);
			bright = (2 * mx * Q15_ONE + LEVEL_TOP) / (2 * LEVEL_TOP);
		end else begin
			sum = mx + mn;
			dev = sum - LEVEL_TOP;
			if (dev < 0)
				dev = -dev;
			den = LEVEL_TOP - dev;
			if (sum != 0 && sum != 2 * LEVEL_TOP && den > 0)
				sat = (2 * chroma * Q15_ONE + den) / (2 * den);
			bright = (2 * sum * Q15_ONE + 2 * LEVEL_TOP) / (4 * LEVEL_TOP);
		end
		res.hue        = h[14:0];
		res.saturation = sat[15:0];
		res.brightness = bright[15:0];
		return res;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		int     kind;
		int     lvl;
		kind = $urandom_range(0, 9);
		px = pixel_t'(24'($urandom));
		case (kind)
			5: begin
				// two channels tied
				case ($urandom_range(0, 2))
					0: px.green = px.red;
					1: px.blue = px.green;
					default: px.blue = px.red;
				endcase
			end
			6: begin
				px.green = px.red;
				px.blue = px.red;
			end
			7: begin
				lvl = $urandom_range(0, 3);
				px.red   = ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^ 8'(lvl & 1);
				px.green = ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^ 8'(lvl >> 1);
				px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			8: begin
				// near grey: chroma of a few levels
				lvl = $urandom_range(0, 251);
				px.red   = 8'(lvl + $urandom_range(0, 4));
				px.green = 8'(lvl + $urandom_range(0, 4));
				px.blue  = 8'(lvl + $urandom_range(0, 4));
			end
			default: ;
		endcase
		return px;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic write_mode(input mode_t mode);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we    <= 1'b0;
		mode_now = mode;
	endtask

	task automatic run_phase(input mode_t mode, input int idle, input int stall,
			input int count, input bit corners);
		write_mode(mode);
		idle_pct  = idle;
		stall_pct = stall;
		if (corners) begin
			foreach (CORNER_PIXELS[i])
				pixel_queue.push_back(pixel_t'(CORNER_PIXELS[i]));
		end
		repeat (count)
			pixel_queue.push_back(random_pixel());
		while (pixel_queue.size() != 0 || offer_open || expected_hsx.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// sender: bursts of items with random gaps, payload held while stalled
	always @(negedge clk) begin
		if (!offer_open) begin
			if (gap_left > 0) begin
				gap_left--;
				pixel_valid <= 1'b0;
				pixel       <= pixel_t'(24'($urandom));
			end else if (pixel_queue.size() != 0) begin
				pixel_valid <= 1'b1;
				pixel       <= pixel_queue.pop_front();
				offer_open = 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
				end
			end else begin
				pixel_valid <= 1'b0;
				pixel       <= pixel_t'(24'($urandom));
			end
		end
	end

	// receiver: random stalls plus one long hold-off to back up the pipeline
	always @(negedge clk) begin
		if (!hold_done && accepted_count >= HOLDOFF_AT) begin
			hold_left = HOLDOFF_LEN;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && !pixel_stall) begin
				expected_hsx.push_back(predict_hsx(pixel, mode_now));
				offer_open = 1'b0;
				accepted_count++;
			end
			if (result_valid && !result_stall) begin
				if (expected_hsx.size() == 0) begin
					report_mismatch($sformatf("unexpected result hue=%0d sat=%0d brt=%0d",
						result.hue, result.saturation, result.brightness));
				end else begin
					result_t want;
					want = expected_hsx.pop_front();
					if (result.hue !== want.hue)
						report_mismatch($sformatf("hue: expected %0d, got %0d",
							want.hue, result.hue));
					if (result.saturation !== want.saturation)
						report_mismatch($sformatf("saturation: expected %0d, got %0d",
							want.saturation, result.saturation));
					if (result.brightness !== want.brightness)
						report_mismatch($sformatf("brightness: expected %0d, got %0d",
							want.brightness, result.brightness));
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 1'b0;
		pixel_valid  = 1'b0;
		pixel        = '0;
		result_stall = 1'b0;
		mode_now     = MODE_HSV;
		offer_open   = 1'b0;
		burst_left   = 0;
		gap_left     = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		accepted_count = 0;
		error_count  = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		run_phase(MODE_HSV, 20, 20, 0, 1'b1);
		run_phase(MODE_HSL, 20, 20, 0, 1'b1);
		run_phase(MODE_HSV, 0, 0, 275, 1'b0);
		run_phase(MODE_HSL, 40, 30, 275, 1'b0);
		run_phase(MODE_HSL, 60, 70, 275, 1'b0);
		run_phase(MODE_HSV, 30, 40, 275, 1'b0);

		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
